@@ rtl/lr4x_pkg.sv @@
// Shared constants for the two-way LR4 crossover.
package lr4x_pkg;

  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_FRAC_BITS_DEF = 30;
  localparam int STATE_BITS_DEF     = 48;

  localparam int COEF_BITS      = 32;
  localparam int GUARD_BITS     = 4;
  localparam int CFG_INDEX_BITS = 3;

  // four biquads: low band stages 0,1 then high band stages 0,1
  localparam int NUM_SECTIONS = 4;
  localparam int SECT_BITS    = 2;
  localparam int ADDR_BITS    = SECT_BITS + 1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_LOWPASS_B0  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HIGHPASS_B0 = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FEEDBACK_A1 = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FEEDBACK_A2 = 3'd3;

  localparam logic signed [COEF_BITS-1:0] LOWPASS_B0_RST  = 32'sd65506;
  localparam logic signed [COEF_BITS-1:0] HIGHPASS_B0_RST = 32'sd1061881271;
  localparam logic signed [COEF_BITS-1:0] FEEDBACK_A1_RST = -32'sd2123632173;
  localparam logic signed [COEF_BITS-1:0] FEEDBACK_A2_RST = 32'sd1050152790;

endpackage

@@ rtl/lr4_two_way_crossover_top.sv @@
// Fourth-order Linkwitz-Riley two-way crossover, one shared multiplier, state in RAM.
//
// Each accepted sample runs through two cascaded lowpass biquads and two cascaded
// highpass biquads (transposed direct form II, shared a1/a2, Q2.30 coefficients);
// low_out is the low band and high_out the negated high band, both saturated.
// The four sections run one after another, each through ST_BX, ST_Y, ST_A1,
// ST_A2 and ST_N2, paced by the single 32x24 multiplier that forms all three
// products of a section and by the registered read of the 8-entry delay RAM;
// ST_DONE then loads the output register. The next sample is taken in ST_IDLE
// once the result word is in the output register, even if it has not been taken
// yet; a new sample is not accepted before the previous one is through, and a
// stalled output word holds the next one in ST_DONE.
// Delay words clear at reset through per-entry valid bits, so no sweep is needed.
// cfg_ready is always high; coefficients must only be written while idle.
module lr4_two_way_crossover_top
  import lr4x_pkg::*;
#(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  parameter int STATE_BITS     = STATE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [SAMPLE_BITS-1:0]    sample_in,
  input  logic                             block_last,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [SAMPLE_BITS-1:0]    low_out,
  output logic signed [SAMPLE_BITS-1:0]    high_out,
  output logic                             block_last_out,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]        cfg_index,
  input  logic [COEF_BITS-1:0]             cfg_data
);

  localparam int STATE_FRAC  = STATE_BITS - SAMPLE_BITS - GUARD_BITS;
  localparam int STATE_SHIFT = COEF_FRAC_BITS - STATE_FRAC;
  localparam int PROD_W      = COEF_BITS + SAMPLE_BITS;
  localparam int ACC_A       = PROD_W + 3;
  localparam int ACC_B       = STATE_BITS + STATE_SHIFT + 1;
  localparam int ACC_W       = ((ACC_A > ACC_B) ? ACC_A : ACC_B) + 1;
  localparam int MEM_DEPTH   = 2 * NUM_SECTIONS;

  localparam logic signed [ACC_W-1:0] ONE = $signed({{(ACC_W-1){1'b0}}, 1'b1});
  localparam logic signed [ACC_W-1:0] RND_Y = ONE <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] RND_S = ONE <<< (STATE_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] SMP_MAX =
    $signed({{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] SMP_MIN = ~SMP_MAX;
  localparam logic signed [ACC_W-1:0] STA_MAX =
    $signed({{(ACC_W-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] STA_MIN = ~STA_MAX;
  localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX =
    $signed({1'b0, {(SAMPLE_BITS-1){1'b1}}});
  localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN = ~OUT_MAX;
  localparam logic [SECT_BITS-1:0] LAST_LOW  = SECT_BITS'(NUM_SECTIONS / 2 - 1);
  localparam logic [SECT_BITS-1:0] LAST_SECT = SECT_BITS'(NUM_SECTIONS - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_BX, ST_Y, ST_A1, ST_A2, ST_N2, ST_DONE
  } state_t;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [ACC_W-1:0] r;
    r = (v + RND_Y) >>> COEF_FRAC_BITS;
    if (r > SMP_MAX) r = SMP_MAX;
    else if (r < SMP_MIN) r = SMP_MIN;
    return r[SAMPLE_BITS-1:0];
  endfunction

  function automatic logic signed [STATE_BITS-1:0] sat_state(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [ACC_W-1:0] r;
    r = (v + RND_S) >>> STATE_SHIFT;
    if (r > STA_MAX) r = STA_MAX;
    else if (r < STA_MIN) r = STA_MIN;
    return r[STATE_BITS-1:0];
  endfunction

  state_t                          state;
  logic [SECT_BITS-1:0]            sect;
  logic signed [COEF_BITS-1:0]     lowpass_b0, highpass_b0, feedback_a1, feedback_a2;
  logic signed [SAMPLE_BITS-1:0]   x_in, sec_x, y, low_res;
  logic                            last_q;
  logic signed [PROD_W-1:0]        bx, prod;
  logic signed [COEF_BITS-1:0]     mul_a;
  logic signed [SAMPLE_BITS-1:0]   mul_b;

  // delay RAM: address {section, tap}, tap 0 = z1, tap 1 = z2
  logic signed [STATE_BITS-1:0]    mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0]            mem_ok;
  logic [ADDR_BITS-1:0]            rd_addr, wr_addr;
  logic                            mem_we;
  logic signed [STATE_BITS-1:0]    wr_data, rd_data;

  logic                            band_hi;
  logic signed [ACC_W-1:0]         z_scaled, bx2, acc_y, acc_n1, acc_n2;
  logic signed [SAMPLE_BITS-1:0]   y_next;

  assign band_hi   = sect[SECT_BITS-1];
  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lowpass_b0  <= LOWPASS_B0_RST;
      highpass_b0 <= HIGHPASS_B0_RST;
      feedback_a1 <= FEEDBACK_A1_RST;
      feedback_a2 <= FEEDBACK_A2_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOWPASS_B0:  lowpass_b0  <= $signed(cfg_data);
        REG_HIGHPASS_B0: highpass_b0 <= $signed(cfg_data);
        REG_FEEDBACK_A1: feedback_a1 <= $signed(cfg_data);
        REG_FEEDBACK_A2: feedback_a2 <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // shared multiplier, the product lands in the cycle after the operands are set
  always_comb begin
    case (state)
      ST_BX: begin
        mul_a = band_hi ? highpass_b0 : lowpass_b0;
        mul_b = sec_x;
      end
      ST_A2: begin
        mul_a = feedback_a2;
        mul_b = y;
      end
      default: begin
        mul_a = feedback_a1;
        mul_b = y;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // z1 is read in ST_BX; z2 is read from ST_Y on and stays in rd_data
  assign rd_addr = {sect, (state != ST_BX)};

  always_comb begin
    z_scaled = $signed(ACC_W'(rd_data)) <<< STATE_SHIFT;
    acc_y    = $signed(ACC_W'(prod)) + z_scaled;
    bx2      = $signed(ACC_W'(bx)) <<< 1;
    acc_n1   = (band_hi ? -bx2 : bx2) - $signed(ACC_W'(prod)) + z_scaled;
    acc_n2   = $signed(ACC_W'(bx)) - $signed(ACC_W'(prod));
    y_next   = sat_sample(acc_y);
  end

  always_comb begin
    mem_we  = (state == ST_A2) || (state == ST_N2);
    wr_addr = {sect, (state == ST_N2)};
    wr_data = (state == ST_N2) ? sat_state(acc_n2) : sat_state(acc_n1);
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_data <= mem_ok[rd_addr] ? mem[rd_addr] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) mem_ok <= '0;
    else if (mem_we) mem_ok[wr_addr] <= 1'b1;
  end

  // sequencer, datapath registers and output word
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sect      <= '0;
      out_valid <= 1'b0;
    end else begin
      // ST_DONE drives out_valid itself
      if (out_valid && !out_stall && state != ST_DONE) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            x_in   <= sample_in;
            sec_x  <= sample_in;
            last_q <= block_last;
            sect   <= '0;
            state  <= ST_BX;
          end
        end
        ST_BX: state <= ST_Y;
        ST_Y: begin
          y     <= y_next;
          bx    <= prod;
          state <= ST_A1;
        end
        ST_A1: state <= ST_A2;
        ST_A2: state <= ST_N2;
        ST_N2: begin
          if (sect == LAST_SECT) begin
            state <= ST_DONE;
          end else begin
            if (sect == LAST_LOW) begin
              low_res <= y;
              sec_x   <= x_in;
            end else begin
              sec_x <= y;
            end
            sect  <= sect + SECT_BITS'(1);
            state <= ST_BX;
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            low_out        <= low_res;
            high_out       <= (y == OUT_MIN) ? OUT_MAX : -y;
            block_last_out <= last_q;
            out_valid      <= 1'b1;
            sect           <= '0;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == ST_BX && sect == '0)
    else $error("accepted word did not start at section zero");

  a_write_own_phase: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> wr_addr[ADDR_BITS-1:1] == sect && (state == ST_A2 || state == ST_N2))
    else $error("delay RAM written outside a section update");

  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    state == ST_N2 && sect == LAST_SECT |=> state == ST_DONE)
    else $error("last section did not finish the word");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("output word loaded outside the done step");

endmodule
